// ----- sv/cgd_pkg.sv -----
// cgd_pkg: shared types and constants of the greedy sequence decoder
// used by cgd_ctrl, cgd_dpath and ctc_greedy_decoder; no dependencies
`default_nettype none

package cgd_pkg;

    localparam int unsigned SCORE_W     = 16;
    localparam int unsigned CLS_W       = 13;
    localparam int unsigned CNT_W       = 14;
    localparam int unsigned KEPT_W      = 8;
    localparam int unsigned SUM_W       = 23;
    localparam int unsigned DICT_W      = 14;
    localparam int unsigned MAX_CLASSES = 8192;
    localparam int unsigned MAX_STEPS   = 128;
    localparam int unsigned DIV_STEPS   = SCORE_W;
    localparam int unsigned STEP_W      = $clog2(DIV_STEPS);

    localparam logic [DICT_W-1:0] DICT_RESET = DICT_W'(8192);
    localparam logic [CLS_W-1:0]  BLANK_CLS  = '0;

    typedef struct packed {
        logic [SCORE_W-1:0] class_score;
        logic               last_of_row;
        logic               last_of_sequence;
    } t_in;

    typedef struct packed {
        logic               emit_char;
        logic [CLS_W-1:0]   class_index;
        logic               sequence_done;
        logic [SCORE_W-1:0] mean_score;
        logic [KEPT_W-1:0]  kept_count;
    } t_out;

    typedef struct packed {
        logic take;
        logic load_out;
        logic div_start;
        logic div_step;
        logic div_last;
    } t_cmd;

    typedef struct packed {
        logic last_row;
        logic need_div;
    } t_sts;

endpackage

`default_nettype wire

// ----- sv/cgd_ctrl.sv -----
// cgd_ctrl: handshake control and divide sequencing of the decoder
// depends on cgd_pkg
`default_nettype none

module cgd_ctrl
    import cgd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);

    typedef enum logic {
        S_RUN,
        S_DIV
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic                out_free;
    logic                can_take;
    logic                take;

    assign out_free = !r_out_valid || !i_out_stall;
    assign can_take = (r_state == S_RUN) && (!i_sts.last_row || out_free);
    assign take     = can_take && i_in_valid;

    assign o_in_stall  = !can_take;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.take      = take;
        o_cmd.load_out  = take && i_sts.last_row;
        o_cmd.div_start = take && i_sts.need_div;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.div_last  = (r_state == S_DIV) && (r_step == STEP_W'(DIV_STEPS - 1));

        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_RUN: begin
                n_step = '0;
                if (o_cmd.div_start) begin
                    n_state = S_DIV;
                end else if (o_cmd.load_out) begin
                    n_out_valid = 1'b1;
                end
            end
            S_DIV: begin
                n_step = r_step + STEP_W'(1);
                if (o_cmd.div_last) begin
                    n_state     = S_RUN;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cgd_dpath.sv -----
// cgd_dpath: row argmax, keep/repeat filter, score accumulation,
// radix-2 mean divider and output register; depends on cgd_pkg
`default_nettype none

module cgd_dpath
    import cgd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [DICT_W-1:0] i_cfg_data,
    input  wire t_in               i_in,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    output t_out                   o_out
);

    logic [DICT_W-1:0]  r_dict;
    logic [SCORE_W-1:0] r_row_max;
    logic [CLS_W-1:0]   r_argmax;
    logic [CNT_W-1:0]   r_cls_cnt;
    logic [CLS_W-1:0]   r_prev;
    logic [SUM_W-1:0]   r_sum;
    logic [KEPT_W-1:0]  r_kept;
    logic [KEPT_W-1:0]  r_rem;
    logic [SCORE_W-1:0] r_q;
    logic [KEPT_W-1:0]  r_div;
    t_out               r_out;

    logic               in_range;
    logic               upd;
    logic [SCORE_W-1:0] cur_max;
    logic [CLS_W-1:0]   cur_arg;
    logic               kept;
    logic               emit;
    logic               add;
    logic               seq_end;
    logic [SUM_W-1:0]   n_sum;
    logic [KEPT_W-1:0]  n_kept;
    logic [KEPT_W:0]    shifted;
    logic               ge;
    logic [KEPT_W:0]    diff;
    logic [KEPT_W-1:0]  n_rem;
    logic [SCORE_W-1:0] n_q;

    always_comb begin
        in_range = r_cls_cnt < CNT_W'(MAX_CLASSES);
        upd      = in_range && ((r_cls_cnt == '0) || (i_in.class_score > r_row_max));
        cur_max  = upd ? i_in.class_score : r_row_max;
        cur_arg  = upd ? r_cls_cnt[CLS_W-1:0] : r_argmax;
        kept     = (cur_arg != BLANK_CLS) && (cur_arg != r_prev);
        emit     = kept && ({1'b0, cur_arg} < r_dict);
        add      = kept && (r_kept < KEPT_W'(MAX_STEPS));
        n_sum    = add ? r_sum + SUM_W'(cur_max) : r_sum;
        n_kept   = add ? r_kept + KEPT_W'(1) : r_kept;
        seq_end  = i_in.last_of_row && i_in.last_of_sequence;

        o_sts.last_row = i_in.last_of_row;
        o_sts.need_div = seq_end && (n_kept != '0);

        shifted = {r_rem, r_q[SCORE_W-1]};
        ge      = shifted >= {1'b0, r_div};
        diff    = shifted - {1'b0, r_div};
        n_rem   = ge ? diff[KEPT_W-1:0] : shifted[KEPT_W-1:0];
        n_q     = {r_q[SCORE_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dict    <= DICT_RESET;
            r_row_max <= '0;
            r_argmax  <= '0;
            r_cls_cnt <= '0;
            r_prev    <= BLANK_CLS;
            r_sum     <= '0;
            r_kept    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dict <= i_cfg_data;
            end
            if (i_cmd.take) begin
                if (i_in.last_of_row) begin
                    r_row_max <= '0;
                    r_argmax  <= '0;
                    r_cls_cnt <= '0;
                    r_prev    <= seq_end ? BLANK_CLS : cur_arg;
                    r_sum     <= seq_end ? '0 : n_sum;
                    r_kept    <= seq_end ? '0 : n_kept;
                end else begin
                    r_row_max <= cur_max;
                    r_argmax  <= cur_arg;
                    if (in_range) begin
                        r_cls_cnt <= r_cls_cnt + CNT_W'(1);
                    end
                end
            end
        end
    end

    // transaction payload and divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.emit_char     <= emit;
            r_out.class_index   <= cur_arg;
            r_out.sequence_done <= seq_end;
            r_out.mean_score    <= '0;
            r_out.kept_count    <= n_kept;
        end
        if (i_cmd.div_start) begin
            r_rem <= KEPT_W'(n_sum[SUM_W-1:SCORE_W]);
            r_q   <= n_sum[SCORE_W-1:0];
            r_div <= n_kept;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
        if (i_cmd.div_last) begin
            r_out.mean_score <= n_q;
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

// ----- sv/ctc_greedy_decoder.sv -----
// ctc_greedy_decoder: top level of the streaming greedy sequence decoder
// depends on cgd_pkg, cgd_ctrl and cgd_dpath
//
// input channel: one class score per transaction, class 0 first, with
// last_of_row on the last score of a time step and last_of_sequence with it
// on the last step. output channel: one transaction per finished row with
// emit flag, argmax class, running kept count and, on the last row, the mean
// kept score. i_cfg_we writes the dictionary size (reset 8192).
// scores inside a row are taken one per cycle while no divide runs and give
// no output. a row end loads the output register, shown in the cycle after
// the transaction. a sequence end with kept rows runs a one-bit-per-cycle
// restoring divider: the result appears once all 16 quotient bits are done,
// and no input is taken meanwhile. a new row end waits while an earlier
// result is still held by the receiver; other scores keep flowing. synchronous
// active-low reset clears the row and sequence state, empties the output
// register and restores the dictionary size.
`default_nettype none

module ctc_greedy_decoder
    import cgd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [DICT_W-1:0] i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in               i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out                   o_out
);

    t_cmd cmd;
    t_sts sts;

    cgd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    cgd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
